[rtl/core/tsu_pkg.sv]
package tsu_pkg;

   localparam int MAX_TOKEN_LEN = 128;
   // run length counts up to one past the maximum so that an overlong token shows
   localparam int RUN_W = $clog2(MAX_TOKEN_LEN + 2);
   localparam int PREFIX_DEPTH = 7;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;
   localparam logic [7:0] MAX_LEN_FIELD = 8'(MAX_TOKEN_LEN % 256);

   typedef enum logic [4:0] {
      KIND_END      = 5'd0,
      KIND_LPAREN   = 5'd1,
      KIND_RPAREN   = 5'd2,
      KIND_LBRACE   = 5'd3,
      KIND_RBRACE   = 5'd4,
      KIND_COMMA    = 5'd5,
      KIND_COLON    = 5'd6,
      KIND_ASSIGN   = 5'd7,
      KIND_DEF      = 5'd8,
      KIND_INTEGER  = 5'd9,
      KIND_STRING   = 5'd10,
      KIND_BOOLEAN  = 5'd11,
      KIND_BOOLCONST = 5'd12,
      KIND_IDENT    = 5'd13,
      KIND_INT      = 5'd14,
      KIND_STR      = 5'd15,
      KIND_ERROR    = 5'd16
   } kind_type;

   typedef enum logic [4:0] {
      MODE_IDLE   = 5'b00001,
      MODE_COLON  = 5'b00010,
      MODE_IDENT  = 5'b00100,
      MODE_NUMBER = 5'b01000,
      MODE_STRING = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       at_end;
   } req_item_type;

   typedef struct packed {
      kind_type    kind;
      logic [30:0] int_value;
      logic        bool_value;
      logic [15:0] line_number;
      logic [31:0] start_offset;
      logic [7:0]  token_length;
      logic        last;
   } rsp_item_type;

   // up to two items per input byte, first one always filled before the second
   typedef struct packed {
      logic         valid0;
      logic         valid1;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

   typedef logic [PREFIX_DEPTH-1:0][7:0] name_prefix_type;

   typedef struct packed {
      logic     hit;
      kind_type kind;
   } kw_result_type;

   function automatic logic [7:0] len_field(input logic [RUN_W-1:0] len);
      logic [31:0] wide;
      wide = 32'(len);
      return wide[7:0];
   endfunction

   // keyword compare over the stored identifier prefix
   function automatic kw_result_type kw_lookup(input name_prefix_type p,
                                               input logic [RUN_W-1:0] len);
      kw_result_type r;
      r.hit = 1'b1;
      r.kind = KIND_IDENT;
      if (len == RUN_W'(3) && p[0] == "d" && p[1] == "e" && p[2] == "f") begin
         r.kind = KIND_DEF;
      end else if (len == RUN_W'(7) && p[0] == "i" && p[1] == "n" && p[2] == "t"
                   && p[3] == "e" && p[4] == "g" && p[5] == "e" && p[6] == "r") begin
         r.kind = KIND_INTEGER;
      end else if (len == RUN_W'(6) && p[0] == "s" && p[1] == "t" && p[2] == "r"
                   && p[3] == "i" && p[4] == "n" && p[5] == "g") begin
         r.kind = KIND_STRING;
      end else if (len == RUN_W'(7) && p[0] == "b" && p[1] == "o" && p[2] == "o"
                   && p[3] == "l" && p[4] == "e" && p[5] == "a" && p[6] == "n") begin
         r.kind = KIND_BOOLEAN;
      end else if (len == RUN_W'(5) && p[0] == "f" && p[1] == "a" && p[2] == "l"
                   && p[3] == "s" && p[4] == "e") begin
         r.kind = KIND_BOOLCONST;
      end else if (len == RUN_W'(4) && p[0] == "t" && p[1] == "r" && p[2] == "u"
                   && p[3] == "e") begin
         r.kind = KIND_BOOLCONST;
      end else begin
         r.hit = 1'b0;
      end
      return r;
   endfunction

endpackage

[rtl/core/tsu_scan_core.sv]
module tsu_scan_core
   import tsu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_valid,
   input  req_item_type step_item,
   output push_type     push
);

   mode_type          mode_ff, mode_in;
   name_prefix_type   prefix_ff, prefix_in;
   logic [RUN_W-1:0]  run_length_ff, run_length_in;
   logic [30:0]       number_acc_ff, number_acc_in;
   logic [15:0]       line_count_ff, line_count_in;
   logic [31:0]       byte_pos_ff, byte_pos_in;
   logic [31:0]       token_start_ff, token_start_in;

   logic [7:0]        ch;
   logic [3:0]        digit;
   logic              is_alpha, is_digit;
   logic              overlong;
   kw_result_type     kw;
   rsp_item_type      flush_tok, disp_tok, tok_a, tok_b;
   logic              flush_hit, disp_hit;
   logic [RUN_W-1:0]  run_ext;
   logic [34:0]       acc_next;

   function automatic rsp_item_type make_tok(input kind_type k, input logic [30:0] iv,
                                             input logic bv, input logic [15:0] ln,
                                             input logic [31:0] st, input logic [7:0] len);
      rsp_item_type t;
      t.kind = k;
      t.int_value = iv;
      t.bool_value = bv;
      t.line_number = ln;
      t.start_offset = st;
      t.token_length = len;
      t.last = 1'b0;
      return t;
   endfunction

   assign ch       = step_item.ch;
   assign digit    = 4'(ch - 8'h30);
   assign is_alpha = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
   assign is_digit = ch >= "0" && ch <= "9";
   assign overlong = run_length_ff > RUN_W'(MAX_TOKEN_LEN);
   assign kw       = kw_lookup(prefix_ff, run_length_ff);
   assign run_ext  = overlong ? run_length_ff : run_length_ff + RUN_W'(1);
   assign acc_next = 35'({number_acc_ff, 3'b000}) + 35'({number_acc_ff, 1'b0}) + 35'(digit);

   // token pending in the current mode
   always_comb begin
      flush_hit = 1'b1;
      flush_tok = make_tok(KIND_ERROR, '0, 1'b0, line_count_ff, token_start_ff,
                           MAX_LEN_FIELD);
      case (mode_ff)
         MODE_COLON: begin
            flush_tok = make_tok(KIND_COLON, '0, 1'b0, line_count_ff, token_start_ff, 8'd1);
         end
         MODE_IDENT: begin
            if (!overlong) begin
               flush_tok = make_tok(kw.hit ? kw.kind : KIND_IDENT, '0,
                                    kw.hit && kw.kind == KIND_BOOLCONST && prefix_ff[0] == "t",
                                    line_count_ff, token_start_ff, len_field(run_length_ff));
            end
         end
         MODE_NUMBER: begin
            if (!overlong) begin
               flush_tok = make_tok(KIND_INT, number_acc_ff, 1'b0, line_count_ff,
                                    token_start_ff, len_field(run_length_ff));
            end
         end
         MODE_STRING: begin
            if (!overlong) begin
               flush_tok.token_length = len_field(run_length_ff);
            end
         end
         default: begin
            flush_hit = 1'b0;
         end
      endcase
   end

   // next state and result items for one accepted item
   always_comb begin
      logic do_flush, do_disp;
      mode_in        = mode_ff;
      prefix_in      = prefix_ff;
      run_length_in  = run_length_ff;
      number_acc_in  = number_acc_ff;
      line_count_in  = line_count_ff;
      byte_pos_in    = byte_pos_ff;
      token_start_in = token_start_ff;
      disp_hit       = 1'b0;
      disp_tok       = make_tok(KIND_ERROR, '0, 1'b0, line_count_ff, byte_pos_ff, 8'd1);
      tok_a          = flush_tok;
      tok_b          = flush_tok;
      do_flush       = 1'b0;
      do_disp        = 1'b0;
      push.valid0    = 1'b0;
      push.valid1    = 1'b0;

      if (step_item.at_end) begin
         mode_in = MODE_IDLE;
         do_flush = flush_hit;
         disp_hit = 1'b1;
         disp_tok = make_tok(KIND_END, '0, 1'b0, line_count_ff, byte_pos_ff, 8'd0);
      end else begin
         byte_pos_in = byte_pos_ff + 32'd1;
         case (mode_ff)
            MODE_COLON: begin
               if (ch == "=") begin
                  mode_in = MODE_IDLE;
                  disp_hit = 1'b1;
                  disp_tok = make_tok(KIND_ASSIGN, '0, 1'b0, line_count_ff,
                                      token_start_ff, 8'd2);
               end else begin
                  do_flush = 1'b1;
                  do_disp = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (is_alpha || is_digit) begin
                  if (run_length_ff < RUN_W'(PREFIX_DEPTH)) begin
                     prefix_in[3'(run_length_ff)] = ch;
                  end
                  run_length_in = run_ext;
               end else begin
                  do_flush = 1'b1;
                  do_disp = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit) begin
                  number_acc_in = (acc_next > 35'(INT_MAX)) ? INT_MAX : acc_next[30:0];
                  if (run_length_ff < RUN_W'(PREFIX_DEPTH)) begin
                     prefix_in[3'(run_length_ff)] = ch;
                  end
                  run_length_in = run_ext;
               end else begin
                  do_flush = 1'b1;
                  do_disp = 1'b1;
               end
            end
            MODE_STRING: begin
               if (run_length_ff < RUN_W'(PREFIX_DEPTH)) begin
                  prefix_in[3'(run_length_ff)] = ch;
               end
               run_length_in = run_ext;
               if (ch == "\"") begin
                  mode_in = MODE_IDLE;
                  disp_hit = 1'b1;
                  if (run_ext > RUN_W'(MAX_TOKEN_LEN)) begin
                     disp_tok = make_tok(KIND_ERROR, '0, 1'b0, line_count_ff,
                                         token_start_ff, MAX_LEN_FIELD);
                  end else begin
                     disp_tok = make_tok(KIND_STR, '0, 1'b0, line_count_ff,
                                         token_start_ff, len_field(run_ext));
                  end
               end
            end
            default: begin
               do_disp = 1'b1;
            end
         endcase

         if (do_disp) begin
            mode_in = MODE_IDLE;
            if (ch == " " || ch == "\t") begin
               disp_hit = 1'b0;
            end else if (ch == "\n") begin
               if (line_count_ff != 16'hFFFF) begin
                  line_count_in = line_count_ff + 16'd1;
               end
            end else if (ch == "(" || ch == ")" || ch == "{" || ch == "}" || ch == ",") begin
               disp_hit = 1'b1;
               disp_tok.kind = (ch == "(") ? KIND_LPAREN :
                               (ch == ")") ? KIND_RPAREN :
                               (ch == "{") ? KIND_LBRACE :
                               (ch == "}") ? KIND_RBRACE : KIND_COMMA;
            end else if (ch == ":" || ch == "\"" || is_alpha || is_digit) begin
               mode_in = (ch == ":") ? MODE_COLON :
                         (ch == "\"") ? MODE_STRING :
                         is_alpha ? MODE_IDENT : MODE_NUMBER;
               token_start_in = byte_pos_ff;
               prefix_in[0] = ch;
               run_length_in = RUN_W'(1);
               if (is_digit) begin
                  number_acc_in = 31'(digit);
               end
            end else begin
               disp_hit = 1'b1;
            end
         end
      end

      if (do_flush) begin
         tok_a = flush_tok;
         tok_b = disp_tok;
         tok_b.last = 1'b1;
         push.valid0 = step_valid;
         push.valid1 = step_valid && disp_hit;
         tok_a.last = !disp_hit;
      end else begin
         tok_a = disp_tok;
         tok_a.last = 1'b1;
         push.valid0 = step_valid && disp_hit;
      end
      push.item0 = tok_a;
      push.item1 = tok_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         run_length_ff  <= '0;
         number_acc_ff  <= '0;
         line_count_ff  <= 16'd1;
         byte_pos_ff    <= '0;
         token_start_ff <= '0;
      end else if (step_valid) begin
         mode_ff        <= mode_in;
         run_length_ff  <= run_length_in;
         number_acc_ff  <= number_acc_in;
         line_count_ff  <= line_count_in;
         byte_pos_ff    <= byte_pos_in;
         token_start_ff <= token_start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_valid) begin
         prefix_ff <= prefix_in;
      end
   end

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_count_ff != 16'd0)
      else $error("line count reached zero");

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      run_length_ff <= RUN_W'(MAX_TOKEN_LEN + 1))
      else $error("run length past overlong mark");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      (step_valid && !step_item.at_end) |=> byte_pos_ff == $past(byte_pos_ff) + 32'd1)
      else $error("byte position did not advance");

endmodule

[rtl/core/tsu_out_queue.sv]
module tsu_out_queue
   import tsu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   output logic         room,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   rsp_item_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               pop;

   // room for two items, so a byte that yields two never waits
   assign room      = count_ff <= QCNT_W'(QUEUE_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_item  = slot_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.valid0) + QPTR_W'(push.valid1);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(push.valid0) + QCNT_W'(push.valid1) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid0) begin
         slot_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.valid1) begin
         slot_ff[wr_ptr_ff + QPTR_W'(1)] <= push.item1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue over capacity");

   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.valid1 |-> push.valid0)
      else $error("second item pushed without first");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (count_ff == QCNT_W'(1) && pop && !push.valid0) |=> count_ff == '0)
      else $error("queue failed to drain");

endmodule

[rtl/core/token_scanner_unit.sv]
// a result item is written into the result queue as the byte that causes it is taken, then offered on rsp in order
// throughput: one byte per cycle while req_ready is high; a byte that yields two items offers them on rsp in turn
// req_ready holds while the four-entry result queue has room for two items
// reset (synchronous, active high): scanner idle, line count one, byte position zero,
// result queue empty; the identifier prefix store is not cleared
module token_scanner_unit
   import tsu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   logic     step_valid;
   push_type push;
   logic     room;

   // an item is taken whenever the queue can absorb its worst case of two results
   assign req_ready  = room;
   assign step_valid = req_valid && req_ready;

   // scanner state and per-byte token decisions
   tsu_scan_core u_scan (
      .clock     (clock),
      .reset     (reset),
      .step_valid(step_valid),
      .step_item (req_item),
      .push      (push)
   );

   // result queue, decouples result stalls from byte intake
   tsu_out_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item)
   );

endmodule
